/* rtl/core/bba_pkg.sv */
// Shared types and constants of the bitmap block allocator.
package bba_pkg;

    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;
    localparam int CNT_REQ_W = 7;
    localparam int BN_W      = 12;

    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_BLOCKS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_PER_GROUP = 2'd1;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_MARK  = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_SHORT = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic                 kind;
        logic [CNT_REQ_W-1:0] request_count;
        logic [BN_W-1:0]      target_block;
    } in_item_t;

    typedef struct packed {
        logic [1:0]      status;
        logic [BN_W-1:0] block_number;
        logic            last;
    } out_item_t;

    typedef enum logic [1:0] {
        OP_REPLY = 2'd0,
        OP_MARK  = 2'd1,
        OP_ALLOC = 2'd2
    } op_t;

    typedef struct packed {
        op_t                  op;
        logic [1:0]           status;
        logic [CNT_REQ_W-1:0] count;
        logic [BN_W-1:0]      target;
    } cmd_t;

endpackage

/* rtl/core/bba_ram.sv */
// Generic simple dual-port RAM with registered read.
module bba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port, then registered read of the old contents
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* rtl/core/bba_front.sv */
// Front end: configuration registers, item classification and command queue.
module bba_front #(
    parameter int MAX_BLOCKS  = 4096,
    parameter int MAX_GROUPS  = 8,
    parameter int MAX_REQUEST = 64,
    parameter int WORD_BITS   = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [bba_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bba_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  bba_pkg::in_item_t                 s_item,
    input  logic                              busy,
    output logic                              clear,
    output logic [$clog2(MAX_BLOCKS+1)-1:0]   eff_total,
    output logic                              cmd_valid,
    input  logic                              cmd_ready,
    output bba_pkg::cmd_t                     cmd
);
    import bba_pkg::*;

    localparam int BIT_W = $clog2(WORD_BITS);
    localparam int CNT_W = $clog2(MAX_BLOCKS+1);
    localparam int EW    = $clog2(MAX_GROUPS*MAX_BLOCKS+1);
    localparam logic [EW-1:0] BPG_MAX = EW'(MAX_BLOCKS - MAX_BLOCKS % WORD_BITS);
    localparam logic [EW-1:0] BPG_MIN = EW'(WORD_BITS);
    localparam logic [EW-1:0] BLK_MAX = EW'(MAX_BLOCKS);

    logic [CFG_W-1:0] tb_reg, bpg_reg;
    logic             clear_reg;
    logic [CNT_W-1:0] eff_reg;
    logic [EW-1:0]    bpg_round, bpg_eff, lim, eff_a, eff_b;

    // hold configuration; a write to either register requests a state rebuild
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tb_reg    <= CFG_W'(4096);
            bpg_reg   <= CFG_W'(512);
            clear_reg <= 1'b0;
        end else begin
            clear_reg <= 1'b0;
            if (cfg_wr_en && cfg_index == REG_TOTAL_BLOCKS) begin
                tb_reg    <= cfg_wdata;
                clear_reg <= 1'b1;
            end else if (cfg_wr_en && cfg_index == REG_BLOCKS_PER_GROUP) begin
                bpg_reg   <= cfg_wdata;
                clear_reg <= 1'b1;
            end
        end
    end

    // effective group size and managed block count
    always_comb begin
        bpg_round = EW'({bpg_reg[CFG_W-1:BIT_W], BIT_W'(0)});
        bpg_eff   = bpg_round;
        if (bpg_round < BPG_MIN) begin
            bpg_eff = BPG_MIN;
        end else if (bpg_round > BPG_MAX) begin
            bpg_eff = BPG_MAX;
        end
        lim   = bpg_eff * EW'(MAX_GROUPS);
        eff_a = (EW'(tb_reg) > BLK_MAX) ? BLK_MAX : EW'(tb_reg);
        eff_b = (eff_a > lim) ? lim : eff_a;
    end

    always_ff @(posedge aclk) begin
        eff_reg <= CNT_W'(eff_b);
    end

    assign clear     = clear_reg;
    assign eff_total = eff_reg;

    // classify the incoming item
    cmd_t cls;
    always_comb begin
        cls.op     = OP_REPLY;
        cls.status = ST_SHORT;
        cls.count  = s_item.request_count;
        cls.target = '0;
        if (s_item.kind == KIND_MARK) begin
            cls.target = s_item.target_block;
            if (32'(s_item.target_block) < 32'(eff_reg)) begin
                cls.op     = OP_MARK;
                cls.status = ST_OK;
            end
        end else if (s_item.request_count == '0) begin
            cls.status = ST_EMPTY;
        end else if (32'(s_item.request_count) <= 32'(MAX_REQUEST)) begin
            cls.op     = OP_ALLOC;
            cls.status = ST_OK;
        end
    end

    // two-entry command queue; hold input while the layout is being rebuilt
    cmd_t       q_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] n_reg;
    logic       push, pop;

    assign s_ready   = !busy && !clear_reg && (n_reg != 2'd2);
    assign push      = s_valid && s_ready;
    assign cmd_valid = (n_reg != 2'd0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = q_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wp_reg] <= cls;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            n_reg  <= 2'd0;
        end else begin
            if (push) begin
                wp_reg <= !wp_reg;
            end
            if (pop) begin
                rp_reg <= !rp_reg;
            end
            n_reg <= n_reg + 2'(push) - 2'(pop);
        end
    end
endmodule

/* rtl/core/bba_back.sv */
// Back end: bitmap clear, mark and first-fit scan, result register.
module bba_back #(
    parameter int MAX_BLOCKS = 4096,
    parameter int WORD_BITS  = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              clear,
    input  logic [$clog2(MAX_BLOCKS+1)-1:0]   eff_total,
    output logic                              busy,
    input  logic                              cmd_valid,
    output logic                              cmd_ready,
    input  bba_pkg::cmd_t                     cmd,
    output logic                              m_valid,
    input  logic                              m_ready,
    output bba_pkg::out_item_t                m_item
);
    import bba_pkg::*;

    localparam int WORDS = MAX_BLOCKS / WORD_BITS;
    localparam int AW    = $clog2(WORDS);
    localparam int BIT_W = $clog2(WORD_BITS);
    localparam int CNT_W = $clog2(MAX_BLOCKS+1);

    typedef enum logic [7:0] {
        S_CLEAR = 8'b00000001,
        S_IDLE  = 8'b00000010,
        S_MRD   = 8'b00000100,
        S_MLD   = 8'b00001000,
        S_ARD   = 8'b00010000,
        S_ALD   = 8'b00100000,
        S_BIT   = 8'b01000000,
        S_REP   = 8'b10000000
    } state_t;

    state_t               state_reg;
    logic [AW-1:0]        wa_reg;
    logic [CNT_W-1:0]     total_free_reg;
    logic [CNT_REQ_W-1:0] rem_reg;
    logic [WORD_BITS-1:0] word_reg;
    logic                 dirty_reg;
    logic [BIT_W-1:0]     bit_reg;
    logic [1:0]           rep_st_reg;
    logic [BN_W-1:0]      rep_bn_reg;
    logic                 out_v_reg;
    out_item_t            out_reg;

    logic                 we;
    logic [WORD_BITS-1:0] wdata, rdata;
    logic [BIT_W-1:0]     zero_idx;
    logic                 out_free;
    logic                 out_load;

    bba_ram #(.WIDTH(WORD_BITS), .DEPTH(WORDS)) u_map (
        .aclk  (aclk),
        .we    (we),
        .waddr (wa_reg),
        .wdata (wdata),
        .raddr (wa_reg),
        .rdata (rdata)
    );

    // lowest free bit of the word under scan
    always_comb begin
        zero_idx = '0;
        for (int i = WORD_BITS-1; i >= 0; i--) begin
            if (!word_reg[i]) begin
                zero_idx = BIT_W'(i);
            end
        end
    end

    assign out_free  = !out_v_reg || m_ready;
    assign busy      = (state_reg == S_CLEAR);
    assign cmd_ready = (state_reg == S_IDLE) && !clear;

    // a new result is loaded in these states once the output slot frees up
    assign out_load = !clear && out_free &&
                      (state_reg == S_MLD || state_reg == S_REP ||
                       (state_reg == S_BIT && rem_reg != '0 && !(&word_reg)));

    // map write port: clearing pass, mark update or scan write-back
    always_comb begin
        we    = 1'b0;
        wdata = word_reg;
        case (state_reg)
            S_CLEAR: begin
                we    = 1'b1;
                wdata = '0;
            end
            S_MLD: begin
                we    = out_free && !rdata[bit_reg];
                wdata = rdata | (WORD_BITS'(1) << bit_reg);
            end
            S_BIT: begin
                we = dirty_reg && (rem_reg == '0 || &word_reg);
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    // set the output valid on a new result, drop it when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (out_load) begin
            out_v_reg <= 1'b1;
        end else if (m_ready) begin
            out_v_reg <= 1'b0;
        end
    end

    // sequence the commands
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            wa_reg    <= '0;
        end else if (clear) begin
            state_reg <= S_CLEAR;
            wa_reg    <= '0;
        end else begin
            case (state_reg)
                S_CLEAR: begin
                    total_free_reg <= eff_total;
                    wa_reg         <= wa_reg + AW'(1);
                    if (wa_reg == AW'(WORDS-1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (cmd_valid) begin
                        rep_st_reg <= cmd.status;
                        rep_bn_reg <= cmd.target;
                        rem_reg    <= cmd.count;
                        case (cmd.op)
                            OP_MARK: begin
                                wa_reg    <= AW'(cmd.target >> BIT_W);
                                bit_reg   <= cmd.target[BIT_W-1:0];
                                state_reg <= S_MRD;
                            end
                            OP_ALLOC: begin
                                if (32'(total_free_reg) < 32'(cmd.count)) begin
                                    rep_st_reg <= ST_SHORT;
                                    rep_bn_reg <= '0;
                                    state_reg  <= S_REP;
                                end else begin
                                    wa_reg    <= '0;
                                    state_reg <= S_ARD;
                                end
                            end
                            default: begin
                                state_reg <= S_REP;
                            end
                        endcase
                    end
                end
                S_MRD: begin
                    state_reg <= S_MLD;
                end
                S_MLD: begin
                    if (out_free) begin
                        if (!rdata[bit_reg] && total_free_reg != '0) begin
                            total_free_reg <= total_free_reg - CNT_W'(1);
                        end
                        out_reg   <= '{status: ST_OK, block_number: rep_bn_reg, last: 1'b1};
                        state_reg <= S_IDLE;
                    end
                end
                S_ARD: begin
                    state_reg <= S_ALD;
                end
                S_ALD: begin
                    word_reg  <= rdata;
                    dirty_reg <= 1'b0;
                    state_reg <= S_BIT;
                end
                S_BIT: begin
                    if (rem_reg == '0) begin
                        state_reg <= S_IDLE;
                    end else if (&word_reg) begin
                        wa_reg    <= wa_reg + AW'(1);
                        state_reg <= S_ARD;
                    end else if (out_free) begin
                        word_reg[zero_idx] <= 1'b1;
                        dirty_reg          <= 1'b1;
                        rem_reg            <= rem_reg - CNT_REQ_W'(1);
                        total_free_reg     <= total_free_reg - CNT_W'(1);
                        out_reg            <= '{status: ST_OK,
                                                block_number: BN_W'({wa_reg, zero_idx}),
                                                last: (rem_reg == CNT_REQ_W'(1))};
                    end
                end
                S_REP: begin
                    if (out_free) begin
                        out_reg   <= '{status: rep_st_reg, block_number: rep_bn_reg,
                                       last: 1'b1};
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_CLEAR;
                end
            endcase
        end
    end

    assign m_valid = out_v_reg;
    assign m_item  = out_reg;

`ifndef SYNTHESIS
    a_free_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_CLEAR && !clear) |-> (total_free_reg <= eff_total))
        else $error("free count above managed total");
    a_clear_load: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(state_reg == S_CLEAR) && state_reg == S_IDLE && !$past(clear))
        |-> (total_free_reg == eff_total))
        else $error("free count not rebuilt by clearing pass");
    a_scan_need: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ARD) |-> (rem_reg != '0))
        else $error("scan advanced with nothing left to allocate");
`endif
endmodule

/* rtl/core/bitmap_block_allocator_unit.sv */
// Top level of the bitmap block allocator.
//
//  port group        dir  handshake          payload
//  s_*               in   s_valid/s_ready    in_item_t  (kind, count, target)
//  m_*               out  m_valid/m_ready    out_item_t (status, block, last)
//  cfg_*             in   cfg_wr_en only     index, 13-bit data
//
// Reply items pass through the command queue, S_REP and the result register;
// mark items also pass S_MRD and S_MLD. An allocation reads each bitmap word
// visited through S_ARD and S_ALD of the single map RAM, then sets free bits.
// After reset and after each write to either configuration register a clearing
// pass zeroes all MAX_BLOCKS/WORD_BITS map words; no item is taken meanwhile.
// A stalled result holds the scan; the front queue keeps accepting two items.
module bitmap_block_allocator_unit #(
    parameter int MAX_BLOCKS  = 4096,
    parameter int MAX_GROUPS  = 8,
    parameter int MAX_REQUEST = 64,
    parameter int WORD_BITS   = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [bba_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bba_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  bba_pkg::in_item_t             s_item,
    output logic                          m_valid,
    input  logic                          m_ready,
    output bba_pkg::out_item_t            m_item
);
    import bba_pkg::*;

    logic                            busy, clear, cmd_valid, cmd_ready;
    logic [$clog2(MAX_BLOCKS+1)-1:0] eff_total;
    cmd_t                            cmd;

    bba_front #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .MAX_GROUPS (MAX_GROUPS),
        .MAX_REQUEST(MAX_REQUEST),
        .WORD_BITS  (WORD_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .busy     (busy),
        .clear    (clear),
        .eff_total(eff_total),
        .cmd_valid(cmd_valid),
        .cmd_ready(cmd_ready),
        .cmd      (cmd)
    );

    bba_back #(
        .MAX_BLOCKS(MAX_BLOCKS),
        .WORD_BITS (WORD_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .clear    (clear),
        .eff_total(eff_total),
        .busy     (busy),
        .cmd_valid(cmd_valid),
        .cmd_ready(cmd_ready),
        .cmd      (cmd),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item)
    );
endmodule
